// File: src/tgh_pkg.sv
package tgh_pkg;

    localparam int CFG_ADDR_W = 4;
    localparam int DATA_W     = 32;

    typedef logic [1:0] t_reg_idx;
    localparam t_reg_idx REG_ORIENT = 2'd0;
    localparam t_reg_idx REG_SIDE   = 2'd1;
    localparam t_reg_idx REG_PITCH  = 2'd2;

    typedef logic [2:0] t_act;
    localparam t_act ACT_RIGHT   = 3'd0;
    localparam t_act ACT_RETURN  = 3'd1;
    localparam t_act ACT_LEFT    = 3'd2;
    localparam t_act ACT_UP      = 3'd3;
    localparam t_act ACT_DOWN    = 3'd4;
    localparam t_act ACT_FORWARD = 3'd5;
    localparam t_act ACT_UNKNOWN = 3'd7;

    localparam logic [3:0]  ORIENT_RST = 4'd0;
    localparam logic [14:0] SIDE_RST   = 15'd4000;
    localparam logic [14:0] PITCH_RST  = 15'd5000;

    typedef struct packed {
        logic [3:0]  orient;
        logic [14:0] side_th;
        logic [14:0] pitch_th;
    } t_cfg;

    typedef struct packed {
        logic clr;
        t_act tilt;
    } t_cls;

    typedef struct packed {
        logic pend_valid;
        t_act pend_act;
        t_act tilt;
    } t_res;

endpackage

// File: src/tilt_gesture_history_classifier_core.sv
// Tilt gesture classifier. Each beat on the push side is either a sample
// (accelerometer X and Y) or a clear request, and produces exactly one result
// beat on the pop side: the pending action state after the update and the
// tilt class of that sample. One beat is accepted per clock while not full;
// the front stage remaps and classifies into a two-entry queue and the back
// stage updates the history and pending action into a two-entry result queue;
// a beat is registered in the front queue and its result in the result queue
// before it shows on the pop side. The user must write configuration through
// the APB port only while no beats are in flight, which is not enforced.
module tilt_gesture_history_classifier_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [tgh_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [tgh_pkg::DATA_W-1:0]        pwdata,
    output logic [tgh_pkg::DATA_W-1:0]        prdata,
    output logic                              pready,
    input  logic                              push,
    output logic                              full,
    input  logic                              i_req_type,
    input  logic signed [15:0]                i_accel_x,
    input  logic signed [15:0]                i_accel_y,
    output logic                              empty,
    input  logic                              pop,
    output logic                              o_pending_valid,
    output logic [2:0]                        o_pending_action,
    output logic [2:0]                        o_current_tilt
);

    tgh_pkg::t_cfg     r_cfg;
    tgh_pkg::t_reg_idx reg_idx;
    tgh_pkg::t_cls     head;
    tgh_pkg::t_res     res;
    logic              cls_empty, cls_pop, wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.orient   <= tgh_pkg::ORIENT_RST;
            r_cfg.side_th  <= tgh_pkg::SIDE_RST;
            r_cfg.pitch_th <= tgh_pkg::PITCH_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                tgh_pkg::REG_ORIENT: r_cfg.orient   <= pwdata[3:0];
                tgh_pkg::REG_SIDE:   r_cfg.side_th  <= pwdata[14:0];
                tgh_pkg::REG_PITCH:  r_cfg.pitch_th <= pwdata[14:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            tgh_pkg::REG_ORIENT: prdata = {28'd0, r_cfg.orient};
            tgh_pkg::REG_SIDE:   prdata = {17'd0, r_cfg.side_th};
            tgh_pkg::REG_PITCH:  prdata = {17'd0, r_cfg.pitch_th};
            default:             prdata = '0;
        endcase
    end

    tgh_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_push     (push),
        .o_full     (full),
        .i_req_type (i_req_type),
        .i_accel_x  (i_accel_x),
        .i_accel_y  (i_accel_y),
        .o_empty    (cls_empty),
        .i_pop      (cls_pop),
        .o_head     (head)
    );

    tgh_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cls_empty (cls_empty),
        .i_cls       (head),
        .o_cls_pop   (cls_pop),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_res       (res)
    );

    assign o_pending_valid  = res.pend_valid;
    assign o_pending_action = res.pend_act;
    assign o_current_tilt   = res.tilt;

endmodule

// File: src/tgh_front.sv
module tgh_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  tgh_pkg::t_cfg        i_cfg,
    input  logic                 i_push,
    output logic                 o_full,
    input  logic                 i_req_type,
    input  logic signed [15:0]   i_accel_x,
    input  logic signed [15:0]   i_accel_y,
    output logic                 o_empty,
    input  logic                 i_pop,
    output tgh_pkg::t_cls        o_head
);

    tgh_pkg::t_cls        r_q [2];
    logic                 r_wp, r_rp;
    logic [1:0]           r_cnt;
    logic [1:0]           n_cnt;
    logic                 push_ok, pop_ok;
    logic signed [15:0]   x_neg, y_neg, x_map, y_map;
    logic signed [16:0]   xs, ys, st, pt, nst, npt;
    tgh_pkg::t_cls        cls;

    function automatic logic signed [15:0] neg_sat(input logic signed [15:0] v);
        return (v == 16'sh8000) ? 16'sh7fff : -v;
    endfunction

    // Remap by orientation, then classify; Y wins over X.
    always_comb begin
        x_neg = i_cfg.orient[0] ? neg_sat(i_accel_x) : i_accel_x;
        y_neg = i_cfg.orient[1] ? neg_sat(i_accel_y) : i_accel_y;
        x_map = i_cfg.orient[3] ? y_neg : x_neg;
        y_map = i_cfg.orient[3] ? x_neg : y_neg;
        xs  = {x_map[15], x_map};
        ys  = {y_map[15], y_map};
        st  = $signed({2'b00, i_cfg.side_th});
        pt  = $signed({2'b00, i_cfg.pitch_th});
        nst = -st;
        npt = -pt;
        cls.clr = i_req_type;
        if (i_req_type) begin
            cls.tilt = tgh_pkg::ACT_UNKNOWN;
        end else if (ys > st) begin
            cls.tilt = tgh_pkg::ACT_LEFT;
        end else if (ys < nst) begin
            cls.tilt = tgh_pkg::ACT_RIGHT;
        end else if (xs > pt) begin
            cls.tilt = tgh_pkg::ACT_UP;
        end else if (xs < npt) begin
            cls.tilt = tgh_pkg::ACT_DOWN;
        end else begin
            cls.tilt = tgh_pkg::ACT_UNKNOWN;
        end
    end

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;
    assign o_head  = r_q[r_rp];

    always_comb begin
        n_cnt = r_cnt;
        if (push_ok && !pop_ok) begin
            n_cnt = r_cnt + 2'd1;
        end else if (pop_ok && !push_ok) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (push_ok) begin
                r_wp <= ~r_wp;
            end
            if (pop_ok) begin
                r_rp <= ~r_rp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_q[r_wp] <= cls;
        end
    end

endmodule

// File: src/tgh_back.sv
module tgh_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cls_empty,
    input  tgh_pkg::t_cls        i_cls,
    output logic                 o_cls_pop,
    output logic                 o_empty,
    input  logic                 i_pop,
    output tgh_pkg::t_res        o_res
);

    // Only the two most recent history entries are ever compared, so only
    // those are kept; older ring entries have no visible effect.
    tgh_pkg::t_act   r_h1, r_h2, n_h1, n_h2;
    logic            r_lat_v, n_lat_v;
    tgh_pkg::t_act   r_lat_a, n_lat_a;
    tgh_pkg::t_res   r_q [2];
    tgh_pkg::t_res   res;
    logic            r_wp, r_rp;
    logic [1:0]      r_cnt;
    logic [1:0]      n_cnt;
    logic            take, pop_ok, upgrade;

    assign take   = !i_cls_empty && (r_cnt != 2'd2);
    assign pop_ok = i_pop && (r_cnt != 2'd0);
    assign o_cls_pop = take;
    assign o_empty   = (r_cnt == 2'd0);
    assign o_res     = r_q[r_rp];

    always_comb begin
        n_h1    = r_h1;
        n_h2    = r_h2;
        n_lat_v = r_lat_v;
        n_lat_a = r_lat_a;
        upgrade = !r_lat_v && (i_cls.tilt == r_h1) && (r_h1 == r_h2)
                  && ((i_cls.tilt == tgh_pkg::ACT_UP) || (i_cls.tilt == tgh_pkg::ACT_DOWN));
        if (i_cls.clr) begin
            n_lat_v = 1'b0;
            n_lat_a = tgh_pkg::ACT_UNKNOWN;
        end else begin
            n_h1 = i_cls.tilt;
            n_h2 = upgrade ? tgh_pkg::ACT_UNKNOWN : r_h1;
            if (!r_lat_v && (i_cls.tilt != tgh_pkg::ACT_UNKNOWN)) begin
                n_lat_v = 1'b1;
                n_lat_a = i_cls.tilt;
            end
            if (upgrade) begin
                n_lat_a = (i_cls.tilt == tgh_pkg::ACT_UP) ? tgh_pkg::ACT_FORWARD
                                                          : tgh_pkg::ACT_RETURN;
            end
        end
        res.pend_valid = n_lat_v;
        res.pend_act   = n_lat_v ? n_lat_a : tgh_pkg::ACT_UNKNOWN;
        res.tilt       = i_cls.tilt;
    end

    always_comb begin
        n_cnt = r_cnt;
        if (take && !pop_ok) begin
            n_cnt = r_cnt + 2'd1;
        end else if (pop_ok && !take) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h1    <= tgh_pkg::ACT_UNKNOWN;
            r_h2    <= tgh_pkg::ACT_UNKNOWN;
            r_lat_v <= 1'b0;
            r_lat_a <= tgh_pkg::ACT_UNKNOWN;
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_cnt   <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (take) begin
                r_h1    <= n_h1;
                r_h2    <= n_h2;
                r_lat_v <= n_lat_v;
                r_lat_a <= n_lat_a;
                r_wp    <= ~r_wp;
            end
            if (pop_ok) begin
                r_rp <= ~r_rp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_q[r_wp] <= res;
        end
    end

endmodule

// File: tb/tilt_gesture_history_classifier_checker.sv
`timescale 1ns / 100ps

module tilt_gesture_history_classifier_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_psel,
    input  logic                           i_penable,
    input  logic                           i_pwrite,
    input  logic                           i_pready,
    input  logic [tgh_pkg::CFG_ADDR_W-1:0] i_paddr,
    input  logic [tgh_pkg::DATA_W-1:0]     i_pwdata,
    input  logic                           i_push,
    input  logic                           i_full,
    input  logic                           i_req_type,
    input  logic signed [15:0]             i_accel_x,
    input  logic signed [15:0]             i_accel_y,
    input  logic                           i_empty,
    input  logic                           i_pop,
    input  logic                           i_pending_valid,
    input  logic [2:0]                     i_pending_action,
    input  logic [2:0]                     i_current_tilt,
    output int                             o_in_flight,
    output int                             o_mismatches
);

    localparam int HIST_DEPTH = 4;

    logic [3:0]  orient;
    logic [14:0] side_th;
    logic [14:0] pitch_th;

    tgh_pkg::t_act tilt_hist [HIST_DEPTH];
    int            hist_ptr;
    logic          pend_valid;
    tgh_pkg::t_act pend_act;

    tgh_pkg::t_res expected_gestures [$];
    int            mismatch_cnt = 0;

    initial begin
        o_in_flight  = 0;
        o_mismatches = 0;
    end

    function automatic int flip_axis(input int v);
        return (v == -32768) ? 32767 : -v;
    endfunction

    // One beat through the gesture state: a sample is classified, logged to history
    // and updates the pending action, a clear drops it; returns what the block should report.
    task automatic predict_gesture(input logic clr, input logic signed [15:0] ax,
                                   input logic signed [15:0] ay,
                                   output tgh_pkg::t_res res);
        int            x;
        int            y;
        int            t;
        int            cur;
        int            p1;
        int            p2;
        tgh_pkg::t_act tilt;
        tilt = tgh_pkg::ACT_UNKNOWN;
        if (clr) begin
            pend_valid = 1'b0;
            pend_act   = tgh_pkg::ACT_UNKNOWN;
        end else begin
            x = ax;
            y = ay;
            if (orient[0]) x = flip_axis(x);
            if (orient[1]) y = flip_axis(y);
            if (orient[3]) begin
                t = x;
                x = y;
                y = t;
            end
            if (y > int'(side_th))
                tilt = tgh_pkg::ACT_LEFT;
            else if (y < -int'(side_th))
                tilt = tgh_pkg::ACT_RIGHT;
            else if (x > int'(pitch_th))
                tilt = tgh_pkg::ACT_UP;
            else if (x < -int'(pitch_th))
                tilt = tgh_pkg::ACT_DOWN;

            cur = (hist_ptr + 1) % HIST_DEPTH;
            hist_ptr = cur;
            tilt_hist[cur] = tilt;
            if (!pend_valid) begin
                p1 = (cur + HIST_DEPTH - 1) % HIST_DEPTH;
                p2 = (cur + HIST_DEPTH - 2) % HIST_DEPTH;
                if (tilt != tgh_pkg::ACT_UNKNOWN) begin
                    pend_valid = 1'b1;
                    pend_act   = tilt;
                end
                // A held pitch tilt upgrades to forward or return and uses up
                // the two older history entries.
                if (tilt_hist[p1] == tilt && tilt_hist[p2] == tilt &&
                    (tilt == tgh_pkg::ACT_UP || tilt == tgh_pkg::ACT_DOWN)) begin
                    pend_valid = 1'b1;
                    pend_act   = (tilt == tgh_pkg::ACT_UP) ? tgh_pkg::ACT_FORWARD
                                                           : tgh_pkg::ACT_RETURN;
                    tilt_hist[p1] = tgh_pkg::ACT_UNKNOWN;
                    tilt_hist[p2] = tgh_pkg::ACT_UNKNOWN;
                end
            end
        end
        res.pend_valid = pend_valid;
        res.pend_act   = pend_valid ? pend_act : tgh_pkg::ACT_UNKNOWN;
        res.tilt       = tilt;
    endtask

    always @(posedge i_clk) begin : monitor
        tgh_pkg::t_res got;
        tgh_pkg::t_res want;
        if (!i_rst_n) begin
            orient     = tgh_pkg::ORIENT_RST;
            side_th    = tgh_pkg::SIDE_RST;
            pitch_th   = tgh_pkg::PITCH_RST;
            for (int i = 0; i < HIST_DEPTH; i++) tilt_hist[i] = tgh_pkg::ACT_UNKNOWN;
            hist_ptr   = HIST_DEPTH - 1;
            pend_valid = 1'b0;
            pend_act   = tgh_pkg::ACT_UNKNOWN;
            expected_gestures.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (tgh_pkg::t_reg_idx'(i_paddr[3:2]))
                    tgh_pkg::REG_ORIENT: orient   = i_pwdata[3:0];
                    tgh_pkg::REG_SIDE:   side_th  = i_pwdata[14:0];
                    tgh_pkg::REG_PITCH:  pitch_th = i_pwdata[14:0];
                    default: ;
                endcase
            end
            if (i_pop && !i_empty) begin
                got.pend_valid = i_pending_valid;
                got.pend_act   = i_pending_action;
                got.tilt       = i_current_tilt;
                if (expected_gestures.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display({"%0t: result beat with nothing expected: ",
                                  "valid=%0b act=%0d tilt=%0d"},
                                 $realtime, got.pend_valid, got.pend_act, got.tilt);
                end else begin
                    want = expected_gestures.pop_front();
                    if (got !== want) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10)
                            $display({"%0t: result mismatch: expected valid=%0b ",
                                      "act=%0d tilt=%0d, got valid=%0b act=%0d tilt=%0d"},
                                     $realtime, want.pend_valid, want.pend_act,
                                     want.tilt, got.pend_valid, got.pend_act, got.tilt);
                    end
                end
            end
            if (i_push && !i_full) begin
                predict_gesture(i_req_type, i_accel_x, i_accel_y, want);
                expected_gestures.insert(expected_gestures.size(), want);
            end
        end
        o_in_flight  <= expected_gestures.size();
        o_mismatches <= mismatch_cnt;
    end

endmodule

// File: tb/tilt_gesture_history_classifier_core_test.sv
`timescale 1ns / 100ps

module tilt_gesture_history_classifier_core_test;

    localparam int RANDOM_PHASES = 8;
    localparam int BEATS_PER_PHASE = 63;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           psel = 1'b0;
    logic                           penable = 1'b0;
    logic                           pwrite = 1'b0;
    logic [tgh_pkg::CFG_ADDR_W-1:0] paddr = '0;
    logic [tgh_pkg::DATA_W-1:0]     pwdata = '0;
    logic [tgh_pkg::DATA_W-1:0]     prdata;
    logic                           pready;
    logic                           push = 1'b0;
    logic                           full;
    logic                           i_req_type = 1'b0;
    logic signed [15:0]             i_accel_x = '0;
    logic signed [15:0]             i_accel_y = '0;
    logic                           empty;
    logic                           pop = 1'b0;
    logic                           o_pending_valid;
    logic [2:0]                     o_pending_action;
    logic [2:0]                     o_current_tilt;

    int in_flight;
    int mismatches;
    int beats_sent = 0;
    int send_burst_left = 0;
    int pop_burst_left = 0;
    int pop_hold_cycles = 0;
    logic [14:0] side_cfg = tgh_pkg::SIDE_RST;
    logic [14:0] pitch_cfg = tgh_pkg::PITCH_RST;

    tilt_gesture_history_classifier_core u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .push             (push),
        .full             (full),
        .i_req_type       (i_req_type),
        .i_accel_x        (i_accel_x),
        .i_accel_y        (i_accel_y),
        .empty            (empty),
        .pop              (pop),
        .o_pending_valid  (o_pending_valid),
        .o_pending_action (o_pending_action),
        .o_current_tilt   (o_current_tilt)
    );

    tilt_gesture_history_classifier_checker u_check (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_psel           (psel),
        .i_penable        (penable),
        .i_pwrite         (pwrite),
        .i_pready         (pready),
        .i_paddr          (paddr),
        .i_pwdata         (pwdata),
        .i_push           (push),
        .i_full           (full),
        .i_req_type       (i_req_type),
        .i_accel_x        (i_accel_x),
        .i_accel_y        (i_accel_y),
        .i_empty          (empty),
        .i_pop            (pop),
        .i_pending_valid  (o_pending_valid),
        .i_pending_action (o_pending_action),
        .i_current_tilt   (o_current_tilt),
        .o_in_flight      (in_flight),
        .o_mismatches     (mismatches)
    );

    always #10 i_clk = ~i_clk;

    initial begin
        #5_000_000;
        $display("tilt_gesture_history_classifier_core verification failed");
        $finish;
    end

    // Called at a rising edge; returns at the edge where the beat is taken.
    task automatic send_beat(input logic req, input logic [15:0] x, input logic [15:0] y);
        int gap;
        if (send_burst_left > 0) begin
            gap = 0;
            send_burst_left--;
        end else begin
            gap = $urandom_range(0, 16);
            if ($urandom_range(0, 31) == 0) send_burst_left = $urandom_range(10, 40);
        end
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push       <= 1'b1;
        i_req_type <= req;
        i_accel_x  <= x;
        i_accel_y  <= y;
        do @(posedge i_clk); while (full);
        beats_sent++;
    endtask

    task automatic send_clear();
        send_beat(1'b1, 16'($urandom), 16'($urandom));
    endtask

    task automatic wait_idle();
        push <= 1'b0;
        do @(posedge i_clk); while (in_flight != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input tgh_pkg::t_reg_idx idx,
                             input logic [tgh_pkg::DATA_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic configure(input logic [3:0] orient, input logic [14:0] side_th,
                             input logic [14:0] pitch_th);
        write_reg(tgh_pkg::REG_ORIENT, tgh_pkg::DATA_W'(orient));
        write_reg(tgh_pkg::REG_SIDE, tgh_pkg::DATA_W'(side_th));
        write_reg(tgh_pkg::REG_PITCH, tgh_pkg::DATA_W'(pitch_th));
        side_cfg  = side_th;
        pitch_cfg = pitch_th;
    endtask

    // Axis values cluster around the threshold edges and the 16-bit extremes.
    function automatic logic [15:0] pick_axis(input int th);
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'(th);
            3: return 16'(th + 1);
            4: return 16'(-th);
            5: return 16'(-(th + 1));
            6: return 16'($urandom);
            default: return 16'($urandom_range(0, 511) - 256);
        endcase
    endfunction

    initial begin : receiver
        int stall;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (pop_hold_cycles > 0) begin
                stall = pop_hold_cycles;
                pop_hold_cycles = 0;
                pop <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            if (pop_burst_left > 0) begin
                stall = 0;
                pop_burst_left--;
            end else begin
                stall = $urandom_range(0, 16);
                if ($urandom_range(0, 31) == 0) pop_burst_left = $urandom_range(10, 40);
            end
            if (stall > 0) begin
                pop <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            pop <= 1'b1;
            do @(posedge i_clk); while (empty);
        end
    end

    initial begin : stimulus
        logic [15:0] gx;
        logic [15:0] gy;
        logic [3:0]  orient;
        logic [14:0] side_th;
        logic [14:0] pitch_th;
        int          phase_end;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part at reset thresholds (side 4000, pitch 5000).
        send_beat(1'b0, 16'sd0, 16'sd4001);
        send_clear();
        send_beat(1'b0, 16'sd5000, 16'sd4000);
        send_beat(1'b0, 16'sd5001, -16'sd4000);
        send_clear();
        send_beat(1'b0, 16'sd5001, 16'sd0);
        send_clear();
        send_beat(1'b0, 16'sd5001, 16'sd0);
        send_clear();
        send_beat(1'b0, -16'sd5001, 16'sd0);
        send_clear();
        send_beat(1'b0, -16'sd5001, 16'sd0);
        send_clear();
        send_beat(1'b0, -16'sd5001, 16'sd0);
        send_clear();
        send_beat(1'b0, 16'h8000, 16'h8000);
        send_clear();
        send_beat(1'b0, 16'h7fff, 16'h7fff);
        send_clear();
        send_beat(1'b0, 16'sd0, 16'sd0);
        send_beat(1'b0, 16'sd0, 16'sd0);
        send_beat(1'b0, 16'sd0, 16'sd0);
        send_clear();
        send_clear();
        wait_idle();
        // Both negations saturate here, then the axes swap.
        configure(4'b1011, tgh_pkg::SIDE_RST, tgh_pkg::PITCH_RST);
        send_beat(1'b0, 16'h8000, 16'h8000);
        send_beat(1'b0, 16'h7fff, 16'h8000);

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            wait_idle();
            case (p)
                0: configure(4'd0, 15'd0, 15'd0);
                1: configure(4'hf, 15'h7fff, 15'h7fff);
                2: configure(4'h4, 15'd1, 15'h7ffe);
                default: begin
                    orient   = 4'($urandom);
                    side_th  = 15'($urandom_range(0, 12000));
                    pitch_th = 15'($urandom_range(0, 12000));
                    configure(orient, side_th, pitch_th);
                end
            endcase
            // Stop draining for a while so both internal queues back up.
            pop_hold_cycles = 80;
            send_burst_left = 30;
            phase_end = beats_sent + BEATS_PER_PHASE;
            while (beats_sent < phase_end) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5: begin
                        // A held tilt: the same sample three times, mostly with
                        // the pending action consumed in between.
                        gx = pick_axis(pitch_cfg);
                        gy = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 63))
                                                         : pick_axis(side_cfg);
                        for (int k = 0; k < 3; k++) begin
                            send_beat(1'b0, gx, gy);
                            if (k < 2 && $urandom_range(0, 3) != 0) send_clear();
                        end
                        if ($urandom_range(0, 1) == 0) send_clear();
                    end
                    6, 7: send_beat(1'b0, pick_axis(pitch_cfg), pick_axis(side_cfg));
                    default: send_clear();
                endcase
            end
        end

        wait_idle();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && in_flight == 0) begin
            $display("tilt_gesture_history_classifier_core verification clean");
        end else begin
            $display("tilt_gesture_history_classifier_core verification failed");
        end
        $finish;
    end

endmodule

// File: sim.f
src/tgh_pkg.sv
src/tgh_front.sv
src/tgh_back.sv
src/tilt_gesture_history_classifier_core.sv
tb/tilt_gesture_history_classifier_checker.sv
tb/tilt_gesture_history_classifier_core_test.sv
